FILE: design/bracket_balance_checker_unit_defines.svh
// Assertion helpers for the bracket checker
`ifndef BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// plain property, checked at each rising edge outside reset
`define BBC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// overlapping implication
`define BBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// implication onto the following edge
`define BBC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBC_ASSERT(lbl, clk, rstn, prop, msg)
`define BBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BBC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: design/bbc_pkg.sv
package bbc_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 256;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int OPEN_W      = 9;
    localparam int STATUS_W    = 3;
    localparam int WIDE_W      = LEVEL_W + OPEN_W;

    // characters of interest
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // bracket kinds held on the stack
    localparam logic [1:0] KIND_PAREN = 2'd0;
    localparam logic [1:0] KIND_BRACK = 2'd1;
    localparam logic [1:0] KIND_BRACE = 2'd2;

    // verdict codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXTRA    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNCLOSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // bracket event from the text filter
    typedef struct packed {
        logic       bracket;
        logic       is_open;
        logic [1:0] kind;
        logic       last;
    } bbc_evt_t;

    // shift control for the stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } bbc_shift_t;

    // verdict towards the output register
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [OPEN_W-1:0]   open_count;
    } bbc_verdict_t;

    // open count saturated to the field width
    function automatic logic [OPEN_W-1:0] sat_open(input logic [LEVEL_W-1:0] lvl);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(lvl);
        if (wide > WIDE_W'({OPEN_W{1'b1}}))
            return {OPEN_W{1'b1}};
        return wide[OPEN_W-1:0];
    endfunction

endpackage

FILE: design/bbc_front.sv
module bbc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_byte,
    input  logic              last_byte,
    input  logic              evt_take,
    output logic              evt_valid,
    output bbc_pkg::bbc_evt_t evt
);

    logic              in_line_comment_reg,  in_line_comment_next;
    logic              in_block_comment_reg, in_block_comment_next;
    logic [7:0]        raw_prev_byte_reg,    raw_prev_byte_next;
    logic              held_slash_reg,       held_slash_next;
    logic [7:0]        kept_prev_byte_reg,   kept_prev_byte_next;
    logic              in_double_quote_reg,  in_double_quote_next;
    logic              in_single_quote_reg,  in_single_quote_next;
    logic              evt_valid_reg,        evt_valid_next;
    bbc_pkg::bbc_evt_t evt_reg,              evt_next;

    logic       accept;
    logic       pass;
    logic       emit_slash;
    logic       emit_char;
    logic       escaped;
    logic [7:0] kept_mid;

    assign in_ready = !evt_valid_reg || evt_take;
    assign accept   = in_valid && in_ready;

    // comment removal, quote removal and bracket decode for one byte
    always_comb
    begin
        in_line_comment_next  = in_line_comment_reg;
        in_block_comment_next = in_block_comment_reg;
        held_slash_next       = held_slash_reg;
        in_double_quote_next  = in_double_quote_reg;
        in_single_quote_next  = in_single_quote_reg;
        raw_prev_byte_next    = char_byte;
        pass                  = 1'b0;
        evt_next              = '0;
        evt_next.last         = last_byte;

        priority if (char_byte == bbc_pkg::CH_SLASH && raw_prev_byte_reg == bbc_pkg::CH_SLASH
                     && !in_line_comment_reg && !in_block_comment_reg)
        begin
            in_line_comment_next = 1'b1;
            held_slash_next      = 1'b0;
        end
        else if (char_byte == bbc_pkg::CH_NL && in_line_comment_reg)
        begin
            pass                 = 1'b1;
            in_line_comment_next = 1'b0;
        end
        else if (char_byte == bbc_pkg::CH_SLASH && raw_prev_byte_reg == bbc_pkg::CH_STAR)
        begin
            in_line_comment_next  = 1'b0;
            in_block_comment_next = 1'b0;
        end
        else if (char_byte == bbc_pkg::CH_STAR && raw_prev_byte_reg == bbc_pkg::CH_SLASH)
        begin
            in_block_comment_next = 1'b1;
            held_slash_next       = 1'b0;
        end
        else if (!in_line_comment_reg && !in_block_comment_reg)
        begin
            pass = 1'b1;
        end
        else
        begin
            pass = 1'b0;
        end

        // a passed byte first releases a held slash; a slash is itself held back
        emit_slash = pass && held_slash_reg;
        emit_char  = pass && (char_byte != bbc_pkg::CH_SLASH);
        if (pass)
            held_slash_next = (char_byte == bbc_pkg::CH_SLASH);

        kept_mid            = emit_slash ? bbc_pkg::CH_SLASH : kept_prev_byte_reg;
        kept_prev_byte_next = emit_char ? char_byte : kept_mid;
        escaped             = (kept_mid == bbc_pkg::CH_BSLASH);

        // quote tracking and bracket decode on the surviving byte
        if (emit_char)
        begin
            priority if (char_byte == bbc_pkg::CH_DQUOTE && !escaped && !in_single_quote_reg)
            begin
                in_double_quote_next = !in_double_quote_reg;
            end
            else if (char_byte == bbc_pkg::CH_SQUOTE && !escaped && !in_double_quote_reg)
            begin
                in_single_quote_next = !in_single_quote_reg;
            end
            else if (!in_double_quote_reg && !in_single_quote_reg)
            begin
                unique case (char_byte)
                    bbc_pkg::CH_LPAREN: evt_next[4:1] = {2'b11, bbc_pkg::KIND_PAREN};
                    bbc_pkg::CH_LBRACK: evt_next[4:1] = {2'b11, bbc_pkg::KIND_BRACK};
                    bbc_pkg::CH_LBRACE: evt_next[4:1] = {2'b11, bbc_pkg::KIND_BRACE};
                    bbc_pkg::CH_RPAREN: evt_next[4:1] = {2'b10, bbc_pkg::KIND_PAREN};
                    bbc_pkg::CH_RBRACK: evt_next[4:1] = {2'b10, bbc_pkg::KIND_BRACK};
                    bbc_pkg::CH_RBRACE: evt_next[4:1] = {2'b10, bbc_pkg::KIND_BRACE};
                    default:            evt_next[4:1] = 4'b0000;
                endcase
            end
            else
            begin
                in_double_quote_next = in_double_quote_reg;
            end
        end

        // end of text: filter state back to its reset value
        if (last_byte)
        begin
            in_line_comment_next  = 1'b0;
            in_block_comment_next = 1'b0;
            raw_prev_byte_next    = 8'd0;
            held_slash_next       = 1'b0;
            kept_prev_byte_next   = 8'd0;
            in_double_quote_next  = 1'b0;
            in_single_quote_next  = 1'b0;
        end
    end

    // event slot occupancy
    always_comb
    begin
        evt_valid_next = evt_valid_reg;
        if (accept)
            evt_valid_next = 1'b1;
        else if (evt_take)
            evt_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_comment_reg  <= 1'b0;
            in_block_comment_reg <= 1'b0;
            raw_prev_byte_reg    <= 8'd0;
            held_slash_reg       <= 1'b0;
            kept_prev_byte_reg   <= 8'd0;
            in_double_quote_reg  <= 1'b0;
            in_single_quote_reg  <= 1'b0;
            evt_valid_reg        <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            if (accept)
            begin
                in_line_comment_reg  <= in_line_comment_next;
                in_block_comment_reg <= in_block_comment_next;
                raw_prev_byte_reg    <= raw_prev_byte_next;
                held_slash_reg       <= held_slash_next;
                kept_prev_byte_reg   <= kept_prev_byte_next;
                in_double_quote_reg  <= in_double_quote_next;
                in_single_quote_reg  <= in_single_quote_next;
            end
        end
    end

    // event payload
    always_ff @(posedge clk)
    begin
        if (accept)
            evt_reg <= evt_next;
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

FILE: design/bbc_cell.sv
module bbc_cell
(
    input  logic                clk,
    input  bbc_pkg::bbc_shift_t shift,
    input  logic [1:0]          from_above,
    input  logic [1:0]          from_below,
    output logic [1:0]          q
);

    logic [1:0] data_reg, data_next;

    // push moves entries down, pop moves them up
    always_comb
    begin
        priority if (shift.push)
            data_next = from_above;
        else if (shift.pop)
            data_next = from_below;
        else
            data_next = data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

FILE: design/bbc_stack.sv
module bbc_stack
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  evt_valid,
    input  bbc_pkg::bbc_evt_t     evt,
    input  logic                  out_free,
    output logic                  evt_take,
    output bbc_pkg::bbc_verdict_t verdict
);

    logic [bbc_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic [bbc_pkg::STATUS_W-1:0] first_error_reg, first_error_next;
    logic [bbc_pkg::STATUS_W-1:0] new_error;
    bbc_pkg::bbc_shift_t          shift;
    logic                         full;
    logic                         empty;
    logic [1:0]                   cell_q [bbc_pkg::STACK_DEPTH];

    assign full     = (level_reg == bbc_pkg::LEVEL_W'(bbc_pkg::STACK_DEPTH));
    assign empty    = (level_reg == '0);
    assign evt_take = evt_valid && (!evt.last || out_free);

    // push/pop decision and first-error capture
    always_comb
    begin
        shift      = '0;
        new_error  = bbc_pkg::ST_OK;
        level_next = level_reg;
        if (evt_take && evt.bracket)
        begin
            if (evt.is_open)
            begin
                if (full)
                    new_error = bbc_pkg::ST_OVERFLOW;
                else
                begin
                    shift.push = 1'b1;
                    level_next = level_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                    new_error = bbc_pkg::ST_EXTRA;
                else
                begin
                    shift.pop  = 1'b1;
                    level_next = level_reg - 1'b1;
                    if (cell_q[0] != evt.kind)
                        new_error = bbc_pkg::ST_MISMATCH;
                end
            end
        end
        first_error_next = (first_error_reg == bbc_pkg::ST_OK) ? new_error : first_error_reg;
    end

    // verdict on the last byte
    always_comb
    begin
        verdict.valid      = evt_take && evt.last;
        verdict.open_count = bbc_pkg::sat_open(level_next);
        if (first_error_next != bbc_pkg::ST_OK)
            verdict.status = first_error_next;
        else if (level_next != '0)
            verdict.status = bbc_pkg::ST_UNCLOSED;
        else
            verdict.status = bbc_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= '0;
            first_error_reg <= bbc_pkg::ST_OK;
        end
        else if (evt_take)
        begin
            if (evt.last)
            begin
                level_reg       <= '0;
                first_error_reg <= bbc_pkg::ST_OK;
            end
            else
            begin
                level_reg       <= level_next;
                first_error_reg <= first_error_next;
            end
        end
    end

    // row of stack cells, top of stack in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < bbc_pkg::STACK_DEPTH; gi++)
        begin : g_cell
            logic [1:0] above;
            logic [1:0] below;
            if (gi == 0)
            begin : g_top
                assign above = evt.kind;
            end
            else
            begin : g_mid
                assign above = cell_q[gi-1];
            end
            if (gi == bbc_pkg::STACK_DEPTH - 1)
            begin : g_bot
                assign below = bbc_pkg::KIND_PAREN;
            end
            else
            begin : g_up
                assign below = cell_q[gi+1];
            end
            bbc_cell u_cell
            (
                .clk        (clk),
                .shift      (shift),
                .from_above (above),
                .from_below (below),
                .q          (cell_q[gi])
            );
        end
    endgenerate

endmodule

FILE: design/bracket_balance_checker_unit.sv
// The last byte's event is registered, then its verdict is registered for m_tdata.
// Throughput: one byte per cycle, set by the push/pop of the stack cell row.
// A verdict waiting in the output register stalls input only when the next last byte arrives.
// Reset (rst_n low, asynchronous) clears filter flags, stack level, error and valid flags;
// stack cells hold no reset value and need no clearing pass.
`include "bracket_balance_checker_unit_defines.svh"

module bracket_balance_checker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [11:3] open_count, [15:12] zero
);

    logic                  evt_valid;
    bbc_pkg::bbc_evt_t     evt;
    logic                  evt_take;
    logic                  out_free;
    bbc_pkg::bbc_verdict_t verdict;
    logic                  out_valid_reg, out_valid_next;
    logic [11:0]           out_data_reg;

    bbc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_byte (s_tdata),
        .last_byte (s_tlast),
        .evt_take  (evt_take),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    bbc_stack u_stack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt       (evt),
        .out_free  (out_free),
        .evt_take  (evt_take),
        .verdict   (verdict)
    );

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (verdict.valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (verdict.valid)
            out_data_reg <= {verdict.open_count, verdict.status};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // checks
    `BBC_ASSERT_NXT(a_last_reaches_stack, clk, rst_n,
        s_tvalid && s_tready && s_tlast, evt_valid && evt.last,
        "last byte lost before stack stage")
    `BBC_ASSERT_IMP(a_no_overwrite, clk, rst_n,
        out_valid_reg && !m_tready, !verdict.valid,
        "pending verdict overwritten")
    `BBC_ASSERT_IMP(a_ok_empty, clk, rst_n,
        m_tvalid && m_tdata[2:0] == bbc_pkg::ST_OK, m_tdata[11:3] == 9'd0,
        "ok verdict with brackets open")
    `BBC_ASSERT_IMP(a_unclosed_open, clk, rst_n,
        m_tvalid && m_tdata[2:0] == bbc_pkg::ST_UNCLOSED, m_tdata[11:3] != 9'd0,
        "unclosed verdict with nothing open")

endmodule

FILE: tb/tb_bracket_balance_checker_unit.sv
`timescale 1ns / 100ps

module tb_bracket_balance_checker_unit;

    import bbc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_BYTES = 1150;
    localparam int MIN_TEXTS    = 40;
    localparam int TAIL_BYTES   = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // one byte of text as it waits for the driver
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_byte_t;

    // one verdict as it leaves the block
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OPEN_W-1:0]   open_count;
    } verdict_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_byte
    logic        s_tlast  = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [2:0] status, [11:3] open_count, [15:12] zero

    bracket_balance_checker_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // stimulus and expectation stores
    text_byte_t pending_bytes[$];
    verdict_t   expected_verdicts[$];
    logic [7:0] text_buf[$];

    int  bytes_total     = 0;
    int  bytes_accepted  = 0;
    int  texts_built     = 0;
    int  verdicts_seen   = 0;
    int  mismatch_count  = 0;
    int  idle_cycles     = 0;
    int  status_seen[0:7];
    logic tail_phase     = 1'b0;

    // checker state mirrored from the block
    logic       line_cmt;
    logic       block_cmt;
    logic [7:0] raw_last;
    logic       slash_held;
    logic [7:0] kept_last;
    logic       in_dq;
    logic       in_sq;
    logic [1:0] open_kinds[0:STACK_DEPTH-1];
    int         open_depth;
    logic [STATUS_W-1:0] first_fault;

    task automatic clear_checker_state();
        line_cmt    = 1'b0;
        block_cmt   = 1'b0;
        raw_last    = 8'h00;
        slash_held  = 1'b0;
        kept_last   = 8'h00;
        in_dq       = 1'b0;
        in_sq       = 1'b0;
        open_depth  = 0;
        first_fault = ST_OK;
    endtask

    task automatic record_fault(input logic [STATUS_W-1:0] code);
        if (first_fault == ST_OK)
            first_fault = code;
    endtask

    // bracket stack: push openers, pop and compare closers
    task automatic track_bracket(input logic [7:0] c);
        logic       is_open;
        logic       is_close;
        logic [1:0] k;
        is_open  = 1'b0;
        is_close = 1'b0;
        k        = KIND_PAREN;
        case (c)
            CH_LPAREN: begin is_open  = 1'b1; k = KIND_PAREN; end
            CH_LBRACK: begin is_open  = 1'b1; k = KIND_BRACK; end
            CH_LBRACE: begin is_open  = 1'b1; k = KIND_BRACE; end
            CH_RPAREN: begin is_close = 1'b1; k = KIND_PAREN; end
            CH_RBRACK: begin is_close = 1'b1; k = KIND_BRACK; end
            CH_RBRACE: begin is_close = 1'b1; k = KIND_BRACE; end
            default: ;
        endcase
        if (is_open)
        begin
            if (open_depth >= STACK_DEPTH)
                record_fault(ST_OVERFLOW);
            else
            begin
                open_kinds[open_depth] = k;
                open_depth++;
            end
        end
        else if (is_close)
        begin
            if (open_depth == 0)
                record_fault(ST_EXTRA);
            else
            begin
                open_depth--;
                if (open_kinds[open_depth] != k)
                    record_fault(ST_MISMATCH);
            end
        end
    endtask

    // quoted text is dropped; a backslash escapes the following quote
    task automatic quote_filter(input logic [7:0] c);
        logic esc;
        esc = (kept_last == CH_BSLASH);
        if (c == CH_DQUOTE && !esc && !in_sq)
            in_dq = !in_dq;
        else if (c == CH_SQUOTE && !esc && in_sq && !in_dq)
            in_sq = 1'b0;
        else if (c == CH_SQUOTE && !esc && !in_sq && !in_dq)
            in_sq = 1'b1;
        else if (!in_dq && !in_sq)
            track_bracket(c);
        kept_last = c;
    endtask

    // a slash waits until the next byte shows it does not open a comment
    task automatic forward_byte(input logic [7:0] c);
        if (slash_held)
        begin
            slash_held = 1'b0;
            quote_filter(CH_SLASH);
        end
        if (c == CH_SLASH)
            slash_held = 1'b1;
        else
            quote_filter(c);
    endtask

    task automatic comment_filter(input logic [7:0] c);
        if (c == CH_SLASH && raw_last == CH_SLASH && !line_cmt && !block_cmt)
        begin
            line_cmt   = 1'b1;
            slash_held = 1'b0;
        end
        else if (c == CH_NL && line_cmt)
        begin
            forward_byte(CH_NL);
            line_cmt = 1'b0;
        end
        else if (c == CH_SLASH && raw_last == CH_STAR)
        begin
            line_cmt  = 1'b0;
            block_cmt = 1'b0;
        end
        else if (c == CH_STAR && raw_last == CH_SLASH)
        begin
            block_cmt  = 1'b1;
            slash_held = 1'b0;
        end
        else if (!line_cmt && !block_cmt)
            forward_byte(c);
        raw_last = c;
    endtask

    // work out the verdict, if any, caused by one accepted byte
    task automatic predict_byte(input logic [7:0] c, input logic last);
        verdict_t v;
        comment_filter(c);
        if (last)
        begin
            if (slash_held)
            begin
                slash_held = 1'b0;
                quote_filter(CH_SLASH);
            end
            if (first_fault != ST_OK)
                v.status = first_fault;
            else
                v.status = (open_depth > 0) ? ST_UNCLOSED : ST_OK;
            v.open_count = (open_depth > 511) ? '1 : OPEN_W'(open_depth);
            expected_verdicts.push_back(v);
            clear_checker_state();
        end
    endtask

    // text building helpers
    function automatic logic [7:0] pick_char(input string chars);
        return chars[$urandom_range(0, chars.len() - 1)];
    endfunction

    function automatic logic [7:0] opener_of(input logic [1:0] k);
        case (k)
            KIND_PAREN: return CH_LPAREN;
            KIND_BRACK: return CH_LBRACK;
            default:    return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(input logic [1:0] k);
        case (k)
            KIND_PAREN: return CH_RPAREN;
            KIND_BRACK: return CH_RBRACK;
            default:    return CH_RBRACE;
        endcase
    endfunction

    function automatic logic [1:0] random_kind();
        case ($urandom_range(0, 2))
            0:       return KIND_PAREN;
            1:       return KIND_BRACK;
            default: return KIND_BRACE;
        endcase
    endfunction

    task automatic add_char(input logic [7:0] c);
        text_buf.push_back(c);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // move the text into the driver queue, marking its final byte
    task automatic end_text();
        text_byte_t tb_item;
        if (text_buf.size() == 0)
            text_buf.push_back(8'h20);
        for (int i = 0; i < text_buf.size(); i++)
        begin
            tb_item.ch   = text_buf[i];
            tb_item.last = (i == text_buf.size() - 1);
            pending_bytes.push_back(tb_item);
        end
        text_buf.delete();
        texts_built++;
    endtask

    // C-like text: code, comments, strings, char literals, mostly balanced
    task automatic build_c_text();
        logic [1:0] opens[$];
        logic [1:0] k;
        int         n_tok;
        int         fault;
        n_tok = $urandom_range(2, 14);
        for (int t = 0; t < n_tok; t++)
        begin
            case ($urandom_range(0, 11))
                0, 1: add_char(pick_char("abxyz_019 =;+-"));
                2, 3:
                begin
                    k = random_kind();
                    opens.push_back(k);
                    add_char(opener_of(k));
                end
                4, 5:
                begin
                    if (opens.size() > 0)
                        add_char(closer_of(opens.pop_back()));
                    else
                        add_char(8'h20);
                end
                6:
                begin
                    add_str("//");
                    repeat ($urandom_range(0, 5)) add_char(pick_char("a ()[]{}\"'"));
                    add_char(CH_NL);
                end
                7:
                begin
                    add_str("/*");
                    repeat ($urandom_range(0, 5)) add_char(pick_char("a ()[]{}\"'\n"));
                    add_str("*/");
                end
                8:
                begin
                    add_char(CH_DQUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            add_char(CH_BSLASH);
                            add_char(pick_char("\"n'("));
                        end
                        else
                            add_char(pick_char("a ()[]{}'/*"));
                    end
                    add_char(CH_DQUOTE);
                end
                9:
                begin
                    add_char(CH_SQUOTE);
                    case ($urandom_range(0, 3))
                        0: add_char(pick_char("az0 "));
                        1: add_char(pick_char("()[]{}\""));
                        2: add_str("\\'");
                        default: add_str("\\n");
                    endcase
                    add_char(CH_SQUOTE);
                end
                10: add_str(" / ");
                default: add_char(pick_char(" \n\t*"));
            endcase
        end
        // close up, sometimes with a fault
        fault = $urandom_range(0, 9);
        if (fault == 0 && opens.size() > 0)
        begin
            k = opens.pop_back();
            add_char(closer_of((k == KIND_BRACE) ? KIND_PAREN : k + 2'd1));
        end
        if (fault != 2)
            while (opens.size() > 0)
                add_char(closer_of(opens.pop_back()));
        if (fault == 1)
            add_char(closer_of(random_kind()));
        if ($urandom_range(0, 9) == 0)
            add_char(CH_SLASH);
        end_text();
    endtask

    // nested run that reads a long stretch of the stack back
    task automatic build_nest_text(input int n_open);
        logic [1:0] opens[$];
        logic [1:0] k;
        repeat (n_open)
        begin
            k = random_kind();
            opens.push_back(k);
            add_char(opener_of(k));
        end
        while (opens.size() > 0)
        begin
            if ($urandom_range(0, 3) == 0)
                add_char(pick_char("a ;"));
            add_char(closer_of(opens.pop_back()));
        end
        end_text();
    endtask

    // raw bytes over the full range, biased towards the characters that matter
    task automatic build_noise_text();
        repeat ($urandom_range(1, 16))
        begin
            if ($urandom_range(0, 1) == 0)
                add_char(8'($urandom_range(0, 255)));
            else
                add_char(pick_char("/*\"'\\\n()[]{}"));
        end
        end_text();
    endtask

    // driver: presents queued bytes, predicts each one on acceptance
    int         gap_left = 0;
    text_byte_t next_byte;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            s_tlast    <= 1'b0;
            tail_phase <= 1'b0;
            gap_left = 0;
            clear_checker_state();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            tail_phase <= (pending_bytes.size() < TAIL_BYTES);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.ch;
                    s_tlast  <= next_byte.last;
                    if (!tail_phase && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(1, 15);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares each verdict with the oldest expectation
    int       stall_left = 0;
    verdict_t want;
    verdict_t got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status     = m_tdata[2:0];
                got.open_count = m_tdata[11:3];
                if (expected_verdicts.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%t: verdict with no text pending: status %0d open %0d",
                                 $realtime, got.status, got.open_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    status_seen[want.status]++;
                    verdicts_seen++;
                    if (got !== want)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("%t: verdict mismatch: expected status %0d open %0d, got status %0d open %0d",
                                     $realtime, want.status, want.open_count,
                                     got.status, got.open_count);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!tail_phase && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%t: no progress for %0d cycles", $realtime, idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [1:0] deep_kind;
        int         deep_at;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;

        // directed texts
        add_str("([{}])");   end_text();   // every bracket kind, balanced
        add_str("(]");       end_text();   // mismatch
        add_str(")(]");      end_text();   // extra closing wins over later mismatch
        add_char(8'hFF); add_char(CH_LBRACE); add_char(8'h00); end_text();   // unclosed
        add_str("//)\n(");   end_text();   // line comment ends at newline
        add_str("/*)*/");    end_text();   // block comment
        add_str("\"\\\"(\""); end_text();  // escaped quote inside a string
        add_str("/");        end_text();   // slash still held at end of text

        // random texts, with one deep text that fills and overflows the stack
        deep_at = $urandom_range(300, 700);
        while (pending_bytes.size() < RANDOM_BYTES || texts_built < MIN_TEXTS)
        begin
            if (deep_at > 0 && pending_bytes.size() >= deep_at)
            begin
                repeat (STACK_DEPTH + 1)
                begin
                    deep_kind = random_kind();
                    add_char(opener_of(deep_kind));
                end
                add_char(8'h20);
                end_text();
                deep_at = 0;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: build_noise_text();
                    3:       build_nest_text($urandom_range(10, 60));
                    default: build_c_text();
                endcase
            end
        end
        bytes_total = pending_bytes.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted < bytes_total)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d texts, %0d bytes, %0d verdicts checked, %0d mismatches",
                 texts_built, bytes_total, verdicts_seen, mismatch_count);
        $display("verdicts by status: ok %0d, mismatch %0d, extra %0d, unclosed %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_MISMATCH], status_seen[ST_EXTRA],
                 status_seen[ST_UNCLOSED], status_seen[ST_OVERFLOW]);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/bbc_pkg.sv
design/bbc_front.sv
design/bbc_cell.sv
design/bbc_stack.sv
design/bracket_balance_checker_unit.sv
tb/tb_bracket_balance_checker_unit.sv
